/* design/met_pkg.sv */
// Shared types, constants and register codes of the Mandelbrot escape-time pixel block.
package met_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_PIXEL_BITS  = 12;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_CELL_COUNT  = 2;

    localparam int COORD_REG_BITS  = 32;
    localparam int STEP_BITS       = 31;
    localparam int LIMIT_BITS      = 16;
    localparam int FIELD_PIX_BITS  = 12;
    localparam int FIELD_CNT_BITS  = 16;
    localparam int HUE_BITS        = 9;
    localparam int HUE_STEP        = 10;
    localparam int HUE_WRAP        = 360;
    localparam int APB_ADDR_BITS   = 5;
    localparam int APB_DATA_BITS   = 32;

    typedef enum logic [2:0] {
        REG_LEFT_REAL  = 3'd0,
        REG_TOP_IMAG   = 3'd1,
        REG_REAL_STEP  = 3'd2,
        REG_IMAG_STEP  = 3'd3,
        REG_ITER_LIMIT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [FIELD_PIX_BITS-1:0] column;
        logic [FIELD_PIX_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [FIELD_CNT_BITS-1:0] iteration_count;
        logic                      inside_set;
        logic [HUE_BITS-1:0]       hue_degrees;
    } result_t;

    // Control part of the token that travels around the ring of cells.
    typedef struct packed {
        logic valid;
        logic done;
        logic in_set;
        logic pending;
    } tok_ctl_t;

endpackage

/* design/met_seed.sv */
// Maps an accepted pixel position to the complex point c, with saturation.
module met_seed #(
    parameter int COORD_WIDTH = 32,
    parameter int PIXEL_BITS  = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   take,
    input  logic [PIXEL_BITS-1:0]                  column_px,
    input  logic [PIXEL_BITS-1:0]                  row_px,
    input  logic signed [met_pkg::COORD_REG_BITS-1:0] left_real,
    input  logic signed [met_pkg::COORD_REG_BITS-1:0] top_imag,
    input  logic [met_pkg::STEP_BITS-1:0]          real_step,
    input  logic [met_pkg::STEP_BITS-1:0]          imag_step,
    output logic                                   seed_valid,
    output logic signed [COORD_WIDTH-1:0]          cr,
    output logic signed [COORD_WIDTH-1:0]          ci
);
    import met_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int PW   = PIXEL_BITS + STEP_BITS;
    localparam int MX1  = (PW > COORD_REG_BITS) ? PW : COORD_REG_BITS;
    localparam int MX2  = (MX1 > W) ? MX1 : W;
    localparam int SW   = MX2 + 2;

    logic          vld_reg, vld_next;
    logic [PW-1:0] rprod_reg, rprod_next;
    logic [PW-1:0] iprod_reg, iprod_next;
    logic signed [SW-1:0] sum_r, sum_i;

    function automatic logic signed [W-1:0] clamp_c(input logic signed [SW-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SW-1:W-1];
        all_zero = ~|v[SW-1:W-1];
        if (all_one || all_zero)
            return v[W-1:0];
        else if (v[SW-1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    assign vld_next   = take;
    assign rprod_next = PW'(column_px) * PW'(real_step);
    assign iprod_next = PW'(row_px) * PW'(imag_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rprod_reg <= rprod_next;
        iprod_reg <= iprod_next;
    end

    assign sum_r = {{(SW-COORD_REG_BITS){left_real[COORD_REG_BITS-1]}}, left_real}
                 + {{(SW-PW){1'b0}}, rprod_reg};
    assign sum_i = {{(SW-COORD_REG_BITS){top_imag[COORD_REG_BITS-1]}}, top_imag}
                 - {{(SW-PW){1'b0}}, iprod_reg};

    assign seed_valid = vld_reg;
    assign cr         = clamp_c(sum_r);
    assign ci         = clamp_c(sum_i);

endmodule

/* design/met_cell.sv */
// One cell of the ring: squares the incoming z, then tests escape and forms the next z.
module met_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [COUNT_BITS-1:0]         limit,
    input  met_pkg::tok_ctl_t             ctl_in,
    input  logic signed [COORD_WIDTH-1:0] zr_in,
    input  logic signed [COORD_WIDTH-1:0] zi_in,
    input  logic signed [COORD_WIDTH-1:0] cr_in,
    input  logic signed [COORD_WIDTH-1:0] ci_in,
    input  logic [COUNT_BITS-1:0]         cnt_in,
    input  logic [met_pkg::HUE_BITS-1:0]  hue_in,
    output met_pkg::tok_ctl_t             ctl_out,
    output logic signed [COORD_WIDTH-1:0] zr_out,
    output logic signed [COORD_WIDTH-1:0] zi_out,
    output logic signed [COORD_WIDTH-1:0] cr_out,
    output logic signed [COORD_WIDTH-1:0] ci_out,
    output logic [COUNT_BITS-1:0]         cnt_out,
    output logic [met_pkg::HUE_BITS-1:0]  hue_out
);
    import met_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int FRAC = W - 4;
    localparam logic [W:0] ESC_BOUND = {3'b001, {(W-2){1'b0}}};
    localparam logic [HUE_BITS-1:0] HSTEP = HUE_BITS'(HUE_STEP);
    localparam logic [HUE_BITS-1:0] HWRAP = HUE_BITS'(HUE_WRAP);

    // Square stage.
    tok_ctl_t              a_ctl_reg, a_ctl_next;
    logic signed [W-1:0]   rr_reg, rr_next;
    logic signed [W-1:0]   ii_reg, ii_next;
    logic signed [W-1:0]   ri_reg, ri_next;
    logic signed [W-1:0]   a_cr_reg, a_ci_reg;
    logic [COUNT_BITS-1:0] a_cnt_reg;
    logic [HUE_BITS-1:0]   a_hue_reg;
    logic signed [2*W-1:0] p_rr, p_ii, p_ri;

    // Update stage.
    tok_ctl_t              b_ctl_reg, b_ctl_next;
    logic signed [W-1:0]   zr_reg, zr_next;
    logic signed [W-1:0]   zi_reg, zi_next;
    logic signed [W-1:0]   b_cr_reg, b_ci_reg;
    logic [COUNT_BITS-1:0] b_cnt_reg, b_cnt_next;
    logic [HUE_BITS-1:0]   b_hue_reg, b_hue_next;
    logic signed [W-1:0]   diff;
    logic [W:0]            mag;
    logic                  escape;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [HUE_BITS-1:0]   hue_inc;

    function automatic logic signed [W-1:0] sat_wide(input logic signed [2*W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[2*W-1:W-1];
        all_zero = ~|v[2*W-1:W-1];
        if (all_one || all_zero)
            return v[W-1:0];
        else if (v[2*W-1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b,
                                                     input logic sub);
        logic signed [W:0] s;
        if (sub)
            s = {a[W-1], a} - {b[W-1], b};
        else
            s = {a[W-1], a} + {b[W-1], b};
        if (s[W] == s[W-1])
            return s[W-1:0];
        else if (s[W])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    assign p_rr = zr_in * zr_in;
    assign p_ii = zi_in * zi_in;
    assign p_ri = zr_in * zi_in;

    assign a_ctl_next = ctl_in;
    assign rr_next    = sat_wide(p_rr >>> FRAC);
    assign ii_next    = sat_wide(p_ii >>> FRAC);
    assign ri_next    = sat_wide(p_ri >>> (FRAC - 1));

    // The squares belong to the z that the previous round produced, so the
    // escape test of that round happens here before the round is counted.
    assign diff    = sat_add(rr_reg, ii_reg, 1'b1);
    assign mag     = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign escape  = mag > ESC_BOUND;
    assign cnt_inc = a_cnt_reg + COUNT_BITS'(1);
    assign hue_inc = (a_hue_reg + HSTEP >= HWRAP) ? a_hue_reg + HSTEP - HWRAP
                                                  : a_hue_reg + HSTEP;

    always_comb
    begin
        b_ctl_next = a_ctl_reg;
        b_cnt_next = a_cnt_reg;
        b_hue_next = a_hue_reg;
        zr_next    = sat_add(diff, a_cr_reg, 1'b0);
        zi_next    = sat_add(ri_reg, a_ci_reg, 1'b0);
        if (a_ctl_reg.valid && !a_ctl_reg.done)
        begin
            priority if (a_ctl_reg.pending && escape)
            begin
                b_ctl_next.done   = 1'b1;
                b_ctl_next.in_set = 1'b0;
            end
            else
            begin
                if (a_ctl_reg.pending)
                begin
                    b_cnt_next = cnt_inc;
                    b_hue_next = hue_inc;
                end
                if (b_cnt_next == limit)
                begin
                    b_ctl_next.done   = 1'b1;
                    b_ctl_next.in_set = 1'b1;
                end
                else
                begin
                    b_ctl_next.pending = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= b_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        ri_reg    <= ri_next;
        a_cr_reg  <= cr_in;
        a_ci_reg  <= ci_in;
        a_cnt_reg <= cnt_in;
        a_hue_reg <= hue_in;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        b_cr_reg  <= a_cr_reg;
        b_ci_reg  <= a_ci_reg;
        b_cnt_reg <= b_cnt_next;
        b_hue_reg <= b_hue_next;
    end

    assign ctl_out = b_ctl_reg;
    assign zr_out  = zr_reg;
    assign zi_out  = zi_reg;
    assign cr_out  = b_cr_reg;
    assign ci_out  = b_ci_reg;
    assign cnt_out = b_cnt_reg;
    assign hue_out = b_hue_reg;

endmodule

/* design/mandelbrot_escape_time_pixel_top.sv */
// Top level of the Mandelbrot escape-time pixel block: registers, seed, ring of cells, result.
//
//  Channel   Direction  Handshake           Payload
//  pix       in         pix_valid/pix_stall pixel_t  (column, row)
//  res       out        res_valid/res_stall result_t (iteration_count, inside_set, hue_degrees)
//  apb       in/out     psel/penable/pready paddr, pwdata, prdata
//
// One pixel is in work at a time. The seed stage forms c in the cycle after the
// transfer; the token then circles a ring of CELL_COUNT cells, each cell running one
// iteration through a square stage and then an add and escape-test stage. A pixel
// ends when it escapes or when its count reaches the limit; the default limit is 256.
// Reset clears all control state and loads the register defaults. A finished result
// waits in the output register while res_stall is high; the next pixel is taken
// meanwhile, and its finished token keeps circling until the output register is free.
module mandelbrot_escape_time_pixel_top #(
    parameter int COORD_WIDTH = met_pkg::DEF_COORD_WIDTH,
    parameter int PIXEL_BITS  = met_pkg::DEF_PIXEL_BITS,
    parameter int COUNT_BITS  = met_pkg::DEF_COUNT_BITS,
    parameter int CELL_COUNT  = met_pkg::DEF_CELL_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  met_pkg::pixel_t                    pix_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output met_pkg::result_t                   res_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [met_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [met_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [met_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import met_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam logic [COUNT_BITS+LIMIT_BITS-1:0] CNT_MAX_WIDE =
        {{LIMIT_BITS{1'b0}}, {COUNT_BITS{1'b1}}};

    // Configuration registers.
    logic signed [COORD_REG_BITS-1:0] left_real_reg, left_real_next;
    logic signed [COORD_REG_BITS-1:0] top_imag_reg, top_imag_next;
    logic [STEP_BITS-1:0]             real_step_reg, real_step_next;
    logic [STEP_BITS-1:0]             imag_step_reg, imag_step_next;
    logic [LIMIT_BITS-1:0]            limit_reg, limit_next;
    logic                             cfg_write;
    reg_idx_t                         cfg_idx;

    // Control.
    logic    busy_reg, busy_next;
    logic    res_valid_reg, res_valid_next;
    result_t res_data_reg, res_data_next;
    logic    take;
    logic    capture;

    logic [COUNT_BITS+LIMIT_BITS-1:0] limit_wide;
    logic [COUNT_BITS-1:0]            limit_eff;
    logic [PIXEL_BITS+FIELD_PIX_BITS-1:0] col_wide, row_wide;
    logic [COUNT_BITS+FIELD_CNT_BITS-1:0] cnt_wide;

    // Seed.
    logic                seed_valid;
    logic signed [W-1:0] seed_cr, seed_ci;

    // Ring.
    tok_ctl_t              ctl_q [CELL_COUNT];
    logic signed [W-1:0]   zr_q  [CELL_COUNT];
    logic signed [W-1:0]   zi_q  [CELL_COUNT];
    logic signed [W-1:0]   cr_q  [CELL_COUNT];
    logic signed [W-1:0]   ci_q  [CELL_COUNT];
    logic [COUNT_BITS-1:0] cnt_q [CELL_COUNT];
    logic [HUE_BITS-1:0]   hue_q [CELL_COUNT];
    logic [CELL_COUNT-1:0] ring_vld;

    tok_ctl_t              ring_ctl;
    logic signed [W-1:0]   ring_zr, ring_zi, ring_cr, ring_ci;
    logic [COUNT_BITS-1:0] ring_cnt;
    logic [HUE_BITS-1:0]   ring_hue;
    tok_ctl_t              last_ctl;

    // APB port: always ready, write on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_comb
    begin
        left_real_next = left_real_reg;
        top_imag_next  = top_imag_reg;
        real_step_next = real_step_reg;
        imag_step_next = imag_step_reg;
        limit_next     = limit_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LEFT_REAL:  left_real_next = pwdata;
                REG_TOP_IMAG:   top_imag_next  = pwdata;
                REG_REAL_STEP:  real_step_next = pwdata[STEP_BITS-1:0];
                REG_IMAG_STEP:  imag_step_next = pwdata[STEP_BITS-1:0];
                REG_ITER_LIMIT: limit_next     = pwdata[LIMIT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LEFT_REAL:  prdata = left_real_reg;
            REG_TOP_IMAG:   prdata = top_imag_reg;
            REG_REAL_STEP:  prdata = {1'b0, real_step_reg};
            REG_IMAG_STEP:  prdata = {1'b0, imag_step_reg};
            REG_ITER_LIMIT: prdata = {{(APB_DATA_BITS-LIMIT_BITS){1'b0}}, limit_reg};
            default:        prdata = '0;
        endcase
    end

    // A limit beyond what the counter holds is clamped to the counter's maximum.
    assign limit_wide = {{COUNT_BITS{1'b0}}, limit_reg};
    assign limit_eff  = (limit_wide > CNT_MAX_WIDE) ? {COUNT_BITS{1'b1}}
                                                    : limit_wide[COUNT_BITS-1:0];

    // Pixel positions are cut to PIXEL_BITS.
    assign col_wide = {{PIXEL_BITS{1'b0}}, pix_data.column};
    assign row_wide = {{PIXEL_BITS{1'b0}}, pix_data.row};

    assign pix_stall = busy_reg;
    assign take      = pix_valid && !busy_reg;

    met_seed #(
        .COORD_WIDTH (COORD_WIDTH),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_seed (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .column_px  (col_wide[PIXEL_BITS-1:0]),
        .row_px     (row_wide[PIXEL_BITS-1:0]),
        .left_real  (left_real_reg),
        .top_imag   (top_imag_reg),
        .real_step  (real_step_reg),
        .imag_step  (imag_step_reg),
        .seed_valid (seed_valid),
        .cr         (seed_cr),
        .ci         (seed_ci)
    );

    // The last cell's token is taken out when finished and the output register is
    // free; otherwise it returns to the first cell.
    assign last_ctl = ctl_q[CELL_COUNT-1];
    assign capture  = last_ctl.valid && last_ctl.done && (!res_valid_reg || !res_stall);

    always_comb
    begin
        ring_zr  = zr_q[CELL_COUNT-1];
        ring_zi  = zi_q[CELL_COUNT-1];
        ring_cr  = cr_q[CELL_COUNT-1];
        ring_ci  = ci_q[CELL_COUNT-1];
        ring_cnt = cnt_q[CELL_COUNT-1];
        ring_hue = hue_q[CELL_COUNT-1];
        ring_ctl = '0;
        priority if (seed_valid)
        begin
            ring_ctl.valid = 1'b1;
            ring_zr        = '0;
            ring_zi        = '0;
            ring_cr        = seed_cr;
            ring_ci        = seed_ci;
            ring_cnt       = '0;
            ring_hue       = '0;
        end
        else if (last_ctl.valid && !capture)
        begin
            ring_ctl = last_ctl;
        end
        else
        begin
            ring_ctl = '0;
        end
    end

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        tok_ctl_t              c_ctl;
        logic signed [W-1:0]   c_zr, c_zi, c_cr, c_ci;
        logic [COUNT_BITS-1:0] c_cnt;
        logic [HUE_BITS-1:0]   c_hue;

        if (g == 0)
        begin : g_head
            assign c_ctl = ring_ctl;
            assign c_zr  = ring_zr;
            assign c_zi  = ring_zi;
            assign c_cr  = ring_cr;
            assign c_ci  = ring_ci;
            assign c_cnt = ring_cnt;
            assign c_hue = ring_hue;
        end
        else
        begin : g_link
            assign c_ctl = ctl_q[g-1];
            assign c_zr  = zr_q[g-1];
            assign c_zi  = zi_q[g-1];
            assign c_cr  = cr_q[g-1];
            assign c_ci  = ci_q[g-1];
            assign c_cnt = cnt_q[g-1];
            assign c_hue = hue_q[g-1];
        end

        met_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .COUNT_BITS  (COUNT_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .limit   (limit_eff),
            .ctl_in  (c_ctl),
            .zr_in   (c_zr),
            .zi_in   (c_zi),
            .cr_in   (c_cr),
            .ci_in   (c_ci),
            .cnt_in  (c_cnt),
            .hue_in  (c_hue),
            .ctl_out (ctl_q[g]),
            .zr_out  (zr_q[g]),
            .zi_out  (zi_q[g]),
            .cr_out  (cr_q[g]),
            .ci_out  (ci_q[g]),
            .cnt_out (cnt_q[g]),
            .hue_out (hue_q[g])
        );

        assign ring_vld[g] = ctl_q[g].valid;
    end

    assign cnt_wide = {{FIELD_CNT_BITS{1'b0}}, last_ctl.valid ? cnt_q[CELL_COUNT-1]
                                                              : {COUNT_BITS{1'b0}}};

    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (take)
            busy_next = 1'b1;
        else if (capture)
            busy_next = 1'b0;
        if (capture)
        begin
            res_valid_next                = 1'b1;
            res_data_next.iteration_count = cnt_wide[FIELD_CNT_BITS-1:0];
            res_data_next.inside_set      = last_ctl.in_set;
            res_data_next.hue_degrees     = last_ctl.in_set ? '0 : hue_q[CELL_COUNT-1];
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_real_reg <= -32'sd536870912;
            top_imag_reg  <= 32'sd402653184;
            real_step_reg <= 31'd1048576;
            imag_step_reg <= 31'd1048576;
            limit_reg     <= 16'd256;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            left_real_reg <= left_real_next;
            top_imag_reg  <= top_imag_next;
            real_step_reg <= real_step_next;
            imag_step_reg <= imag_step_next;
            limit_reg     <= limit_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // A transfer on the pixel channel always starts work.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy_reg)
        else $error("pixel taken but block not busy");

    // A finished token only exists while a pixel is in work.
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> busy_reg)
        else $error("result captured while idle");

    // A captured result is offered on the next cycle.
    a_capture_out: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> res_valid_reg)
        else $error("captured result not presented");

    // At most one token is on the ring, including the seed stage.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({seed_valid, ring_vld}))
        else $error("more than one token in the ring");

endmodule

/* tb/tb_mandelbrot_escape_time_pixel_top.sv */
// Self-checking testbench for the Mandelbrot escape-time pixel block.
//
// Pixels go in over the valid/stall channel and escape results are checked
// field by field against an in-bench fixed-point model of the iteration.
// The run has three parts:
//  - a directed table of view settings and pixels,
//  - random phases with fresh register settings, including the extremes,
//  - a long receiver hold-off that fills the block up.
module tb_mandelbrot_escape_time_pixel_top;
    import met_pkg::*;

    localparam longint COORD_MAX  = 64'sd2147483647;
    localparam longint COORD_MIN  = -64'sd2147483648;
    localparam int     FRAC       = DEF_COORD_WIDTH - 4;
    localparam longint ESCAPE_R2  = 64'sd4 <<< FRAC;
    localparam int     CYCLE_CAP  = 4000000;
    localparam int     PHASES     = 8;
    localparam int     PER_PHASE  = 125;
    localparam int     HOLD_LEN   = 3000;

    logic        clk;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    pixel_t      pix_data;
    logic        res_valid;
    logic        res_stall;
    result_t     res_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic        pready;

    mandelbrot_escape_time_pixel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Our own copy of the view registers, kept in step with every APB write.
    longint      view_left;
    longint      view_top;
    longint      view_rstep;
    longint      view_istep;
    int unsigned view_limit;

    result_t     pending_results[$];
    int          error_count = 0;
    int          pixels_sent;
    int          cycle_count = 0;
    logic        long_hold;

    // One row of the directed table: either a register write or a pixel.
    typedef struct {
        bit       is_cfg;
        reg_idx_t idx;
        logic [31:0] value;
        pixel_t   px;
        bit       typed;
        result_t  want;
    } plan_row_t;

    plan_row_t plan[$];

    // The clock runs free from time zero.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // Fixed-point product, floored by the arithmetic shift, then saturated.
    function automatic longint fixed_mul(longint a, longint b, int shift);
        longint prod;
        prod = a * b;
        return clamp_coord(prod >>> shift);
    endfunction

    // Escape-time iteration for one pixel under the current view.
    function automatic result_t escape_result(pixel_t p);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      rr;
        longint      ii;
        longint      ri2;
        int unsigned cnt;
        result_t     r;
        cr  = clamp_coord(view_left + longint'(p.column) * view_rstep);
        ci  = clamp_coord(view_top - longint'(p.row) * view_istep);
        zr  = 0;
        zi  = 0;
        cnt = 0;
        while (cnt < view_limit)
        begin
            rr  = fixed_mul(zr, zr, FRAC);
            ii  = fixed_mul(zi, zi, FRAC);
            ri2 = fixed_mul(zr, zi, FRAC - 1);
            zr  = clamp_coord(clamp_coord(rr - ii) + cr);
            zi  = clamp_coord(ri2 + ci);
            rr  = fixed_mul(zr, zr, FRAC);
            ii  = fixed_mul(zi, zi, FRAC);
            if (clamp_coord(rr + ii) > ESCAPE_R2)
                break;
            cnt++;
        end
        r.iteration_count = cnt[FIELD_CNT_BITS-1:0];
        r.inside_set      = (cnt == view_limit);
        r.hue_degrees     = r.inside_set ? '0 : HUE_BITS'((cnt * HUE_STEP) % HUE_WRAP);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycle_count, got, want);
        error_count++;
    endtask

    // Result side: every transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", res_data.iteration_count, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_data.iteration_count !== want.iteration_count)
                    report_mismatch("iteration_count", res_data.iteration_count,
                                    want.iteration_count);
                if (res_data.inside_set !== want.inside_set)
                    report_mismatch("inside_set", res_data.inside_set, want.inside_set);
                if (res_data.hue_degrees !== want.hue_degrees)
                    report_mismatch("hue_degrees", res_data.hue_degrees, want.hue_degrees);
            end
        end
    end

    // Receiver stall pattern. The first third of the pixels sees heavy stalls,
    // the second third light ones, the rest none; the long hold overrides it.
    always @(posedge clk)
    begin
        int pct;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            pct = (pixels_sent < 333) ? 86 : (pixels_sent < 666) ? 6 : 0;
            res_stall <= long_hold || ($urandom_range(99, 0) < pct);
        end
    end

    // Long hold-off in the middle of the run: results back up, the block stops
    // taking pixels, and the sender keeps offering meanwhile.
    initial
    begin
        long_hold = 1'b0;
        wait (pixels_sent >= 420);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Register write through the APB port, mirrored into the model copy.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEFT_REAL:  view_left  = longint'(signed'(value));
            REG_TOP_IMAG:   view_top   = longint'(signed'(value));
            REG_REAL_STEP:  view_rstep = longint'(value & 32'h7FFF_FFFF);
            REG_IMAG_STEP:  view_istep = longint'(value & 32'h7FFF_FFFF);
            REG_ITER_LIMIT: view_limit = value & 32'h0000_FFFF;
            default: ;
        endcase
    endtask

    // Registers change only with the block empty: every result must be back.
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one pixel, with the sender gap pattern of the current third.
    task automatic send_pixel(pixel_t p, bit typed, result_t want);
        int pct;
        pct = (pixels_sent < 333) ? 6 : (pixels_sent < 666) ? 86 : 0;
        if ($urandom_range(99, 0) < pct)
        begin
            pix_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < pct);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        do @(posedge clk); while (pix_stall);
        pending_results.push_back(typed ? want : escape_result(p));
        pixels_sent++;
    endtask

    function automatic plan_row_t cfg_row(reg_idx_t idx, logic [31:0] value);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        r.px     = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic plan_row_t pix_row(int col, int row, bit typed,
                                          int cnt = 0, bit ins = 0, int hue = 0);
        plan_row_t r;
        r.is_cfg    = 1'b0;
        r.idx       = REG_LEFT_REAL;
        r.value     = '0;
        r.px.column = FIELD_PIX_BITS'(col);
        r.px.row    = FIELD_PIX_BITS'(row);
        r.typed     = typed;
        r.want.iteration_count = FIELD_CNT_BITS'(cnt);
        r.want.inside_set      = ins;
        r.want.hue_degrees     = HUE_BITS'(hue);
        return r;
    endfunction

    // Fresh register settings for one random phase. Phases from four on look at the
    // interesting part of the plane with small limits; the first four take extreme, zero or unconstrained values.
    task automatic pick_view(int phase);
        case (phase)
            0:
            begin
                write_reg(REG_LEFT_REAL,  32'h7FFF_FFFF);
                write_reg(REG_TOP_IMAG,   32'h7FFF_FFFF);
                write_reg(REG_REAL_STEP,  32'h7FFF_FFFF);
                write_reg(REG_IMAG_STEP,  32'h7FFF_FFFF);
                write_reg(REG_ITER_LIMIT, 32'h0000_FFFF);
            end
            1:
            begin
                // The whole screen collapses onto the origin: every pixel is inside.
                write_reg(REG_LEFT_REAL,  32'h0);
                write_reg(REG_TOP_IMAG,   32'h0);
                write_reg(REG_REAL_STEP,  32'h0);
                write_reg(REG_IMAG_STEP,  32'h0);
                write_reg(REG_ITER_LIMIT, $urandom_range(200, 1));
            end
            2:
            begin
                write_reg(REG_LEFT_REAL,  32'h8000_0000);
                write_reg(REG_TOP_IMAG,   32'h8000_0000);
                write_reg(REG_ITER_LIMIT, 32'd1);
            end
            3:
            begin
                // Unconstrained register values.
                write_reg(REG_LEFT_REAL,  $urandom());
                write_reg(REG_TOP_IMAG,   $urandom());
                write_reg(REG_REAL_STEP,  $urandom() >> $urandom_range(31, 0));
                write_reg(REG_IMAG_STEP,  $urandom() >> $urandom_range(31, 0));
                write_reg(REG_ITER_LIMIT, $urandom_range(64, 0));
            end
            default:
            begin
                // Left edge about -2.5..-2.25, top edge about 1.375..1.5, steps 2^-11..2^-8.
                write_reg(REG_LEFT_REAL,  32'(-671088640 + $signed($urandom_range(67108864, 0))));
                write_reg(REG_TOP_IMAG,   32'(402653184 - $urandom_range(33554432, 0)));
                write_reg(REG_REAL_STEP,  $urandom_range(1 << 20, 1 << 17));
                write_reg(REG_IMAG_STEP,  $urandom_range(1 << 20, 1 << 17));
                write_reg(REG_ITER_LIMIT, $urandom_range(60, 2));
            end
        endcase
    endtask

    initial
    begin
        pixel_t  p;
        result_t none;
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        pix_data    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pixels_sent = 0;
        none        = '0;

        // Register values after reset: -2.0, 1.5, 2^-8, 2^-8 and a limit of 256.
        view_left  = -64'sd536870912;
        view_top   = 64'sd402653184;
        view_rstep = 64'sd1048576;
        view_istep = 64'sd1048576;
        view_limit = 256;

        // Directed table. Column 512, row 384 is c = 0 under the reset view,
        // which never escapes; the corners escape in the first round.
        plan.push_back(pix_row(0, 0, 1, 0, 0, 0));
        plan.push_back(pix_row(4095, 4095, 1, 0, 0, 0));
        plan.push_back(pix_row(512, 384, 1, 256, 1, 0));
        plan.push_back(pix_row(4095, 0, 0));
        plan.push_back(pix_row(0, 4095, 0));
        plan.push_back(pix_row(256, 384, 0));
        plan.push_back(pix_row(600, 400, 0));
        plan.push_back(pix_row(450, 300, 0));
        plan.push_back(pix_row(2730, 1365, 0));
        // A zero limit runs no round at all: count 0 and inside for any pixel.
        plan.push_back(cfg_row(REG_ITER_LIMIT, 32'd0));
        plan.push_back(pix_row(512, 384, 1, 0, 1, 0));
        plan.push_back(pix_row(0, 0, 1, 0, 1, 0));
        plan.push_back(cfg_row(REG_ITER_LIMIT, 32'd1));
        plan.push_back(pix_row(512, 384, 1, 1, 1, 0));
        plan.push_back(pix_row(0, 0, 1, 0, 0, 0));
        plan.push_back(cfg_row(REG_ITER_LIMIT, 32'd40));
        plan.push_back(pix_row(700, 420, 0));
        plan.push_back(pix_row(640, 450, 0));
        plan.push_back(pix_row(380, 250, 0));
        plan.push_back(pix_row(1365, 2730, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                pix_valid <= 1'b0;
                wait_idle();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each under its own view settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pix_valid <= 1'b0;
            wait_idle();
            pick_view(ph);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                p.column = FIELD_PIX_BITS'($urandom());
                p.row    = FIELD_PIX_BITS'($urandom());
                send_pixel(p, 1'b0, none);
            end
        end
        pix_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
design/met_pkg.sv
design/met_seed.sv
design/met_cell.sv
design/mandelbrot_escape_time_pixel_top.sv
tb/tb_mandelbrot_escape_time_pixel_top.sv
